// ===== rtl/core/rrca_pkg.sv =====
package rrca_pkg;

   localparam int SEQ_BITS        = 24;
   localparam int TAG_BITS        = 16;
   localparam int BYTES_BITS      = 11;
   localparam int KIND_BITS       = 2;
   localparam int WINDOW_DEF      = 32;
   localparam int MAX_PAYLOAD_DEF = 1024;
   localparam int FINAL_ACKS      = 5;
   localparam int FIN_CNT_BITS    = $clog2(FINAL_ACKS);

   typedef logic [KIND_BITS-1:0] kind_type;

   localparam kind_type KIND_DELIVER   = 2'd0;
   localparam kind_type KIND_ACK       = 2'd1;
   localparam kind_type KIND_FINAL_ACK = 2'd2;

   typedef struct packed {
      logic                  func;
      logic [SEQ_BITS-1:0]   seq_number;
      logic [BYTES_BITS-1:0] byte_count;
      logic [TAG_BITS-1:0]   payload_tag;
      logic [SEQ_BITS-1:0]   last_sequence;
   } req_type;

   typedef struct packed {
      kind_type              kind;
      logic [SEQ_BITS-1:0]   delivered_seq;
      logic [BYTES_BITS-1:0] delivered_bytes;
      logic [TAG_BITS-1:0]   delivered_tag;
      logic [SEQ_BITS-1:0]   ack_number;
      logic                  last_of_run;
   } rsp_type;

   // stored descriptor of one reorder slot
   typedef struct packed {
      logic [BYTES_BITS-1:0] bytes;
      logic [TAG_BITS-1:0]   tag;
   } slot_type;

   typedef struct packed {
      logic load;
      logic calc;
      logic end_mark;
      logic store;
      logic read;
      logic deliver;
      logic ack;
      logic final_ack;
      logic final_last;
   } dp_cmd_type;

   typedef struct packed {
      logic is_end;
      logic done;
      logic off_zero;
      logic head_valid;
      logic ack_hit;
      logic out_free;
   } dp_sts_type;

endpackage

// ===== rtl/core/reorder_receiver_cumulative_ack.sv =====
// Receive side of a sliding-window transfer with a reorder window.
//
// req channel: one beat per packet descriptor (data packet or end marker),
// valid/ready. rsp channel: deliver, ack and final-ack beats, valid/ready;
// last_of_run marks the final beat caused by one descriptor.
//
// Sequence: a data packet that releases nothing passes through capture,
// window offset, slot store and ack. Each packet released from the window
// adds a slot memory read, then the deliver beat, and a release run adds
// one more read that finds the head slot empty. The closing burst adds five
// final-ack beats, one per cycle while rsp_ready does not stall. An end
// marker is captured and decoded and produces no beat. The rate is set by
// the control sequencer, which handles one descriptor at a time, and by the
// single read port of the slot memory during a release run.
//
// Reset clears the window valid bits and all sequence state; req_ready rises
// in the cycle after reset drops. A stall on rsp_ready holds the sequencer
// with the pending beat in the output register; a new descriptor is still
// taken while a finished beat waits. After the final acks every descriptor
// is accepted and dropped.
module reorder_receiver_cumulative_ack #(
   parameter int WINDOW      = rrca_pkg::WINDOW_DEF,
   parameter int MAX_PAYLOAD = rrca_pkg::MAX_PAYLOAD_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rrca_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rrca_pkg::rsp_type rsp_payload
);
   import rrca_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer: handles end markers and walks each data packet through offset, store, release and ack
   rrca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // window state, slot memory and output register
   rrca_datapath #(
      .WINDOW      (WINDOW),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/core/rrca_ctrl.sv =====
module rrca_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rrca_pkg::dp_sts_type sts,
   output rrca_pkg::dp_cmd_type cmd
);
   import rrca_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC,
      S_STORE,
      S_READ,
      S_DELIV,
      S_ACK,
      S_FIN
   } state_type;

   state_type               state_ff, state_in;
   logic                    ready_ff, ready_in;
   logic [FIN_CNT_BITS-1:0] cnt_ff, cnt_in;

   assign req_ready = ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ready_in = ready_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               ready_in = 1'b0;
               state_in = S_CALC;
            end else begin
               ready_in = 1'b1;
            end
         end
         S_CALC: begin
            if (sts.done) begin
               // drop everything once the transfer has ended
               state_in = S_IDLE;
               ready_in = 1'b1;
            end else if (sts.is_end) begin
               cmd.end_mark = 1'b1;
               state_in     = S_IDLE;
               ready_in     = 1'b1;
            end else begin
               cmd.calc = 1'b1;
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.store = 1'b1;
            state_in  = sts.off_zero ? S_READ : S_ACK;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = sts.head_valid ? S_DELIV : S_ACK;
         end
         S_DELIV: begin
            if (sts.out_free) begin
               cmd.deliver = 1'b1;
               state_in    = S_READ;
            end
         end
         S_ACK: begin
            if (sts.ack_hit) begin
               cnt_in   = '0;
               state_in = S_FIN;
            end else if (sts.out_free) begin
               cmd.ack  = 1'b1;
               state_in = S_IDLE;
               ready_in = 1'b1;
            end
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.final_ack = 1'b1;
               if (cnt_ff == FIN_CNT_BITS'(FINAL_ACKS - 1)) begin
                  cmd.final_last = 1'b1;
                  state_in       = S_IDLE;
                  ready_in       = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
            ready_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after a beat was taken");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.deliver || cmd.ack || cmd.final_ack) |-> sts.out_free)
      else $error("result issued into an occupied output register");

   a_final_done: assert property (@(posedge clock) disable iff (reset)
      cmd.final_last |=> sts.done)
      else $error("transfer not marked done after the last final ack");

endmodule

// ===== rtl/core/rrca_datapath.sv =====
module rrca_datapath #(
   parameter int WINDOW      = rrca_pkg::WINDOW_DEF,
   parameter int MAX_PAYLOAD = rrca_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rrca_pkg::req_type    req_payload,
   input  rrca_pkg::dp_cmd_type cmd,
   output rrca_pkg::dp_sts_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rrca_pkg::rsp_type    rsp_payload
);
   import rrca_pkg::*;

   localparam int HEAD_W = $clog2(WINDOW);
   localparam logic [HEAD_W:0]   WIN_EXT  = (HEAD_W + 1)'(WINDOW);
   localparam logic [HEAD_W-1:0] HEAD_TOP = HEAD_W'(WINDOW - 1);

   req_type               in_ff;
   logic [SEQ_BITS-1:0]   next_ff;
   logic [SEQ_BITS-1:0]   ack_ff;
   logic [SEQ_BITS-1:0]   final_ff;
   logic                  end_known_ff;
   logic                  done_ff;
   logic [HEAD_W-1:0]     head_ff;
   logic [HEAD_W-1:0]     off_ff;
   logic                  in_win_ff;
   logic                  off_zero_ff;
   logic [WINDOW-1:0]     valid_ff;
   slot_type              mem [WINDOW];
   slot_type              rd_ff;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff;

   logic [SEQ_BITS-1:0]   diff;
   logic [HEAD_W:0]       sum;
   logic [HEAD_W-1:0]     idx;
   logic [HEAD_W-1:0]     head_next;
   logic [BYTES_BITS-1:0] byte_sat;
   logic                  do_store;
   logic                  emit;

   assign diff      = in_ff.seq_number - next_ff;
   assign sum       = {1'b0, head_ff} + {1'b0, off_ff};
   assign idx       = (sum >= WIN_EXT) ? HEAD_W'(sum - WIN_EXT) : sum[HEAD_W-1:0];
   assign head_next = (head_ff == HEAD_TOP) ? '0 : head_ff + 1'b1;
   assign byte_sat  = (int'(in_ff.byte_count) > MAX_PAYLOAD) ?
                      BYTES_BITS'(MAX_PAYLOAD) : in_ff.byte_count;
   assign do_store  = cmd.store && in_win_ff && !valid_ff[idx];
   assign emit      = cmd.deliver || cmd.ack || cmd.final_ack;

   always_comb begin
      rsp_in = '0;
      if (cmd.deliver) begin
         rsp_in.kind            = KIND_DELIVER;
         rsp_in.delivered_seq   = next_ff;
         rsp_in.delivered_bytes = rd_ff.bytes;
         rsp_in.delivered_tag   = rd_ff.tag;
      end else if (cmd.ack) begin
         rsp_in.kind        = KIND_ACK;
         rsp_in.ack_number  = ack_ff;
         rsp_in.last_of_run = 1'b1;
      end else begin
         rsp_in.kind        = KIND_FINAL_ACK;
         rsp_in.ack_number  = ack_ff;
         rsp_in.last_of_run = cmd.final_last;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff      <= '0;
         ack_ff       <= '0;
         final_ff     <= '0;
         end_known_ff <= 1'b0;
         done_ff      <= 1'b0;
         head_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.end_mark && !end_known_ff) begin
            final_ff <= in_ff.last_sequence;
            if (in_ff.last_sequence >= next_ff) begin
               end_known_ff <= 1'b1;
            end else begin
               done_ff <= 1'b1;
            end
         end
         if (do_store) begin
            valid_ff[idx] <= 1'b1;
         end
         if (cmd.read && !valid_ff[head_ff]) begin
            ack_ff <= next_ff - 1'b1;
         end
         if (cmd.deliver) begin
            valid_ff[head_ff] <= 1'b0;
            head_ff           <= head_next;
            next_ff           <= next_ff + 1'b1;
         end
         if (cmd.final_last) begin
            done_ff <= 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers and slot memory
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff <= req_payload;
      end
      if (cmd.calc) begin
         off_ff      <= diff[HEAD_W-1:0];
         in_win_ff   <= (diff < SEQ_BITS'(WINDOW));
         off_zero_ff <= (diff == '0);
      end
      if (do_store) begin
         mem[idx] <= '{bytes: byte_sat, tag: in_ff.payload_tag};
      end
      if (cmd.read) begin
         rd_ff <= mem[head_ff];
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign sts.is_end     = in_ff.func;
   assign sts.done       = done_ff;
   assign sts.off_zero   = off_zero_ff;
   assign sts.head_valid = valid_ff[head_ff];
   assign sts.ack_hit    = end_known_ff && (ack_ff == final_ff);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_deliver_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> valid_ff[head_ff])
      else $error("delivery from an empty slot");

   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("transfer done flag cleared");

endmodule
